// ----- src/fscrc_pkg.sv -----
`timescale 1ns / 1ps

package fscrc_pkg;

    localparam int unsigned KIND_W = 3;
    localparam int unsigned LEN_W  = 16;

    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 3'd0;
    localparam logic [KIND_W-1:0] KIND_GOOD    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CRCERR  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TIMEOUT = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REPLY   = 3'd4;

    localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
    localparam logic [7:0]  CODE_TIMEOUT  = 8'h80;
    localparam logic [7:0]  CODE_CRC_ERR  = 8'h82;
    localparam logic [7:0]  CHAR_F        = 8'h46;
    localparam logic [7:0]  CHAR_0        = 8'h30;
    localparam logic [7:0]  CHAR_2        = 8'h32;
    localparam logic [15:0] TIMEOUT_RESET = 16'd3000;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LENLO,
        PH_PAYLOAD,
        PH_CRC
    } phase_t;

    typedef enum logic [2:0] {
        BURST_PAYLOAD,
        BURST_GOOD,
        BURST_IDENT,
        BURST_TIMEOUT,
        BURST_CRCERR
    } burst_t;

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0] data);
        logic [31:0] crc;
        crc = crc_in ^ {24'd0, data};
        for (int i = 0; i < 8; i++) begin
            crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
        end
        return crc;
    endfunction

    localparam logic [31:0] REPLY_CRC_TIMEOUT = crc32_byte(CRC_INIT, CODE_TIMEOUT) ^ CRC_INIT;
    localparam logic [31:0] REPLY_CRC_CRCERR  = crc32_byte(CRC_INIT, CODE_CRC_ERR) ^ CRC_INIT;

endpackage

// ----- src/framed_serial_crc32_receiver_unit.sv -----
`timescale 1ns / 1ps

// Channel | Handshake         | Payload
// s_      | s_valid / s_ready | s_operation, s_rx_byte
// m_      | m_valid / m_ready | m_out_kind, m_out_byte, m_frame_length, m_last
// cfg_    | cfg_we            | cfg_wdata (timeout_ticks)
//
// An input transfer updates the frame state and, if it produces results, loads a result burst
// into the output register; a burst holds 1, 3 or 8 results, one per output cycle while m_ready is high.
// A new item is taken in every cycle while the output register is empty or its last result moves.
// Items that produce no result are taken subject to the same condition and leave the output register empty.
// Reset is synchronous on aresetn low and clears the frame state and empties the output register.
// A stalled output holds the result in place and blocks the input until its last result moves.

module framed_serial_crc32_receiver_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_operation,
    input  logic [7:0]                        s_rx_byte,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [fscrc_pkg::KIND_W-1:0]      m_out_kind,
    output logic [7:0]                        m_out_byte,
    output logic [fscrc_pkg::LEN_W-1:0]       m_frame_length,
    output logic                              m_last,
    input  logic                              cfg_we,
    input  logic [15:0]                       cfg_wdata
);
    import fscrc_pkg::*;

    logic [15:0] timeout_reg;
    phase_t      phase_reg, phase_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] count_reg, count_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] rxcrc_reg, rxcrc_next;
    logic [2:0]  crc_cnt_reg, crc_cnt_next;
    logic [15:0] ticks_reg, ticks_next;

    logic        out_valid_reg;
    burst_t      burst_reg;
    logic [7:0]  byte_reg;
    logic [15:0] len_reg;
    logic [2:0]  idx_reg;

    logic        emit;
    burst_t      emit_burst;
    logic [15:0] emit_len;
    logic        tmo_hit;
    logic        s_fire;
    logic        m_fire;
    logic [2:0]  last_idx;
    logic [31:0] reply_crc;
    logic [15:0] tick_inc;
    logic [31:0] crc_upd;
    logic [15:0] count_inc;

    assign s_fire  = s_valid && s_ready;
    assign m_fire  = out_valid_reg && m_ready;
    assign s_ready = !out_valid_reg || (m_ready && m_last);

    assign tick_inc  = (ticks_reg == 16'hFFFF) ? ticks_reg : ticks_reg + 16'd1;
    assign tmo_hit   = (tick_inc > timeout_reg);
    assign crc_upd   = crc32_byte(crc_reg, s_rx_byte);
    assign count_inc = count_reg + 16'd1;

    always_comb begin
        phase_next   = phase_reg;
        length_next  = length_reg;
        count_next   = count_reg;
        crc_next     = crc_reg;
        rxcrc_next   = rxcrc_reg;
        crc_cnt_next = crc_cnt_reg;
        ticks_next   = ticks_reg;
        emit         = 1'b0;
        emit_burst   = BURST_PAYLOAD;
        emit_len     = length_reg;
        if (s_operation) begin
            if (phase_reg == PH_PAYLOAD || phase_reg == PH_CRC) begin
                ticks_next = tick_inc;
                if (tmo_hit) begin
                    emit       = 1'b1;
                    emit_burst = BURST_TIMEOUT;
                    phase_next = PH_IDLE;
                end
            end
        end else begin
            case (phase_reg)
                PH_IDLE: begin
                    if (s_rx_byte == CHAR_F) begin
                        emit       = 1'b1;
                        emit_burst = BURST_IDENT;
                        emit_len   = '0;
                    end else begin
                        length_next = {s_rx_byte, 8'd0};
                        phase_next  = PH_LENLO;
                    end
                end
                PH_LENLO: begin
                    length_next  = {length_reg[15:8], s_rx_byte};
                    count_next   = '0;
                    crc_next     = CRC_INIT;
                    rxcrc_next   = '0;
                    crc_cnt_next = '0;
                    ticks_next   = '0;
                    phase_next   = ({length_reg[15:8], s_rx_byte} == 16'd0) ? PH_CRC
                                                                             : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    emit       = 1'b1;
                    emit_burst = BURST_PAYLOAD;
                    crc_next   = crc_upd;
                    count_next = count_inc;
                    if (count_inc == length_reg) begin
                        crc_cnt_next = '0;
                        rxcrc_next   = '0;
                        phase_next   = PH_CRC;
                    end
                end
                PH_CRC: begin
                    rxcrc_next   = {rxcrc_reg[23:0], s_rx_byte};
                    crc_cnt_next = crc_cnt_reg + 3'd1;
                    if (crc_cnt_next[2]) begin
                        phase_next = PH_IDLE;
                        emit       = 1'b1;
                        emit_burst = (rxcrc_next == ~crc_reg) ? BURST_GOOD : BURST_CRCERR;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_we) begin
            timeout_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            length_reg  <= '0;
            count_reg   <= '0;
            crc_reg     <= CRC_INIT;
            rxcrc_reg   <= '0;
            crc_cnt_reg <= '0;
            ticks_reg   <= '0;
        end else if (s_fire) begin
            phase_reg   <= phase_next;
            length_reg  <= length_next;
            count_reg   <= count_next;
            crc_reg     <= crc_next;
            rxcrc_reg   <= rxcrc_next;
            crc_cnt_reg <= crc_cnt_next;
            ticks_reg   <= ticks_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else if (s_fire) begin
            out_valid_reg <= emit;
            idx_reg       <= '0;
        end else if (m_fire) begin
            if (m_last) begin
                out_valid_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && emit) begin
            burst_reg <= emit_burst;
            byte_reg  <= s_rx_byte;
            len_reg   <= emit_len;
        end
    end

    always_comb begin
        case (burst_reg)
            BURST_PAYLOAD: last_idx = 3'd0;
            BURST_GOOD:    last_idx = 3'd0;
            BURST_IDENT:   last_idx = 3'd2;
            default:       last_idx = 3'd7;
        endcase
    end

    assign reply_crc = (burst_reg == BURST_TIMEOUT) ? REPLY_CRC_TIMEOUT : REPLY_CRC_CRCERR;

    always_comb begin
        m_out_kind = KIND_REPLY;
        m_out_byte = 8'd0;
        case (burst_reg)
            BURST_PAYLOAD: begin
                m_out_kind = KIND_PAYLOAD;
                m_out_byte = byte_reg;
            end
            BURST_GOOD: begin
                m_out_kind = KIND_GOOD;
            end
            BURST_IDENT: begin
                m_out_byte = (idx_reg == 3'd2) ? CHAR_2 : CHAR_0;
            end
            default: begin
                case (idx_reg)
                    3'd0: m_out_kind = (burst_reg == BURST_TIMEOUT) ? KIND_TIMEOUT
                                                                    : KIND_CRCERR;
                    3'd1: m_out_byte = 8'h00;
                    3'd2: m_out_byte = 8'h01;
                    3'd3: m_out_byte = (burst_reg == BURST_TIMEOUT) ? CODE_TIMEOUT
                                                                    : CODE_CRC_ERR;
                    3'd4: m_out_byte = reply_crc[31:24];
                    3'd5: m_out_byte = reply_crc[23:16];
                    3'd6: m_out_byte = reply_crc[15:8];
                    default: m_out_byte = reply_crc[7:0];
                endcase
            end
        endcase
    end

    assign m_valid        = out_valid_reg;
    assign m_frame_length = len_reg;
    assign m_last         = (idx_reg == last_idx);

    a_idx_in_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (idx_reg <= last_idx))
        else $error("Result index ran past the end of its burst.");

    a_no_accept_mid_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_last) |-> !s_ready)
        else $error("Input taken while a burst still has results to deliver.");

    a_burst_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_fire && !m_last) |=> (out_valid_reg && (idx_reg == $past(idx_reg) + 3'd1)))
        else $error("Burst did not advance to its next result.");

    a_timeout_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_operation && (phase_reg == PH_PAYLOAD || phase_reg == PH_CRC) && tmo_hit)
        |=> (phase_reg == PH_IDLE && out_valid_reg && burst_reg == BURST_TIMEOUT))
        else $error("Timeout did not return the receiver to idle with a timeout burst.");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;

    import fscrc_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic       op;
        logic [7:0] data;
    } rx_item_t;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [7:0]        data;
        logic [LEN_W-1:0]  flen;
        logic              last;
    } res_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_operation = 1'b0;
    logic [7:0]            s_rx_byte = 8'h00;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [KIND_W-1:0]     m_out_kind;
    logic [7:0]            m_out_byte;
    logic [LEN_W-1:0]      m_frame_length;
    logic                  m_last;
    logic                  cfg_we = 1'b0;
    logic [15:0]           cfg_wdata = 16'h0000;

    rx_item_t rx_feed_q[$];
    res_t     want_q[$];
    res_t     burst_q[$];

    phase_t        rx_phase = PH_IDLE;
    logic [15:0]   rx_len = 16'h0000;
    logic [15:0]   rx_count = 16'h0000;
    logic [31:0]   rx_crc_run = CRC_INIT;
    logic [31:0]   rx_crc_got = 32'h0;
    logic [2:0]    rx_crc_cnt = 3'd0;
    logic [15:0]   rx_ticks = 16'h0000;
    logic [15:0]   tmo_cfg = TIMEOUT_RESET;

    int n_queued = 0;
    int n_in = 0;
    int n_out = 0;
    int n_good = 0;
    int n_crcerr = 0;
    int n_timeout = 0;
    int n_settings = 0;
    int mismatches = 0;
    int tx_gap = 0;
    int tx_calm = 0;
    int rx_gap = 0;
    int rx_calm = 0;
    int hold_left = 0;
    int hold_seen = 0;
    int hold_at = 40;
    int stall_cycles = 0;
    rx_item_t next_item;
    res_t     want_r;
    logic [15:0] mid_settings [4] = '{16'd1, 16'd2, 16'd5, 16'd12};

    framed_serial_crc32_receiver_unit u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_kind     (m_out_kind),
        .m_out_byte     (m_out_byte),
        .m_frame_length (m_frame_length),
        .m_last         (m_last),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic logic [31:0] crc32_shift(input logic [31:0] c, input logic [7:0] d);
        logic fb;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ d[i];
            c = {1'b0, c[31:1]};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic int pick_gap(inout int calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm > 0) begin
            calm = calm - 1;
            return 0;
        end
        if (r < 2) begin
            calm = $urandom_range(30, 80);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic emit_res(input logic [KIND_W-1:0] k, input logic [7:0] d,
                            input logic [15:0] l);
        burst_q.push_back('{k, d, l, 1'b0});
    endtask

    task automatic emit_reply(input logic [7:0] code);
        logic [31:0] c;
        c = crc32_shift(CRC_INIT, code) ^ CRC_INIT;
        emit_res(KIND_REPLY, 8'h00, rx_len);
        emit_res(KIND_REPLY, 8'h01, rx_len);
        emit_res(KIND_REPLY, code, rx_len);
        emit_res(KIND_REPLY, c[31:24], rx_len);
        emit_res(KIND_REPLY, c[23:16], rx_len);
        emit_res(KIND_REPLY, c[15:8], rx_len);
        emit_res(KIND_REPLY, c[7:0], rx_len);
    endtask

    task automatic track_frame(input logic op, input logic [7:0] d);
        res_t r;
        burst_q.delete();
        if (op) begin
            if (rx_phase == PH_PAYLOAD || rx_phase == PH_CRC) begin
                if (rx_ticks != 16'hFFFF) rx_ticks = rx_ticks + 16'd1;
                if (rx_ticks > tmo_cfg) begin
                    emit_res(KIND_TIMEOUT, 8'h00, rx_len);
                    emit_reply(CODE_TIMEOUT);
                    rx_phase = PH_IDLE;
                end
            end
        end else begin
            case (rx_phase)
                PH_IDLE: begin
                    if (d == CHAR_F) begin
                        emit_res(KIND_REPLY, CHAR_0, 16'd0);
                        emit_res(KIND_REPLY, CHAR_0, 16'd0);
                        emit_res(KIND_REPLY, CHAR_2, 16'd0);
                    end else begin
                        rx_len = {d, 8'h00};
                        rx_phase = PH_LENLO;
                    end
                end
                PH_LENLO: begin
                    rx_len[7:0] = d;
                    rx_count = 16'd0;
                    rx_crc_run = CRC_INIT;
                    rx_crc_got = 32'h0;
                    rx_crc_cnt = 3'd0;
                    rx_ticks = 16'd0;
                    rx_phase = (rx_len == 16'd0) ? PH_CRC : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    emit_res(KIND_PAYLOAD, d, rx_len);
                    rx_crc_run = crc32_shift(rx_crc_run, d);
                    rx_count = rx_count + 16'd1;
                    if (rx_count == rx_len) begin
                        rx_crc_cnt = 3'd0;
                        rx_crc_got = 32'h0;
                        rx_phase = PH_CRC;
                    end
                end
                default: begin
                    rx_crc_got = {rx_crc_got[23:0], d};
                    rx_crc_cnt = rx_crc_cnt + 3'd1;
                    if (rx_crc_cnt >= 3'd4) begin
                        rx_phase = PH_IDLE;
                        if (rx_crc_got == (rx_crc_run ^ CRC_INIT)) begin
                            emit_res(KIND_GOOD, 8'h00, rx_len);
                        end else begin
                            emit_res(KIND_CRCERR, 8'h00, rx_len);
                            emit_reply(CODE_CRC_ERR);
                        end
                    end
                end
            endcase
        end
        foreach (burst_q[i]) begin
            r = burst_q[i];
            r.last = (i == burst_q.size() - 1);
            want_q.push_back(r);
        end
    endtask

    task automatic put_byte(input logic [7:0] d);
        rx_feed_q.push_back('{1'b0, d});
        n_queued++;
    endtask

    task automatic put_tick();
        rx_feed_q.push_back('{1'b1, 8'h00});
        n_queued++;
    endtask

    task automatic put_ticks(input int n);
        repeat (n) put_tick();
    endtask

    task automatic put_frame(input logic [15:0] len, input bit corrupt, input int tick_budget,
                             input bit lenlo_tick, input int fill);
        logic [31:0] c;
        logic [7:0]  d;
        int          budget;
        c = CRC_INIT;
        budget = tick_budget;
        put_byte(len[15:8]);
        if (lenlo_tick) put_tick();
        put_byte(len[7:0]);
        for (int i = 0; i < len; i++) begin
            d = (fill < 0) ? 8'($urandom_range(0, 255)) : fill[7:0];
            c = crc32_shift(c, d);
            put_byte(d);
            if (budget > 0 && $urandom_range(0, 3) == 0) begin
                put_tick();
                budget--;
            end
        end
        c = c ^ CRC_INIT;
        if (corrupt) c = c ^ (32'h1 << $urandom_range(0, 31));
        for (int j = 3; j >= 0; j--) begin
            put_byte(c[8*j +: 8]);
            if (j != 0 && budget > 0 && $urandom_range(0, 3) == 0) begin
                put_tick();
                budget--;
            end
        end
    endtask

    task automatic put_stalled_frame();
        logic [15:0] len;
        int          k;
        len = 16'($urandom_range(0, 65535));
        if (len[15:8] == CHAR_F) len[8] = ~len[8];
        put_byte(len[15:8]);
        put_byte(len[7:0]);
        if (len == 16'd0) k = $urandom_range(0, 3);
        else k = $urandom_range(0, (len < 16'd5) ? int'(len) - 1 : 4);
        repeat (k) put_byte(8'($urandom_range(0, 255)));
        put_ticks(int'(tmo_cfg) + 1);
    endtask

    // Brings the receiver back to idle from any phase, provided the timeout is small.
    task automatic put_resync();
        put_ticks(int'(tmo_cfg) + 1);
        put_byte(8'h00);
        put_byte(8'h00);
        put_ticks(int'(tmo_cfg) + 1);
    endtask

    task automatic run_random(input int n_items, input bit with_timeouts);
        int          start;
        int          r;
        int          budget;
        logic [15:0] len;
        start = n_queued;
        while (n_queued - start < n_items) begin
            r = $urandom_range(0, 99);
            if (!with_timeouts) r = r % 75;
            budget = (tmo_cfg < 16'd3) ? int'(tmo_cfg) : 3;
            len = ($urandom_range(0, 4) != 0) ? 16'($urandom_range(0, 6))
                                               : 16'($urandom_range(7, 40));
            if (r < 50) begin
                put_frame(len, 1'b0, budget, 1'($urandom_range(0, 1)), -1);
            end else if (r < 65) begin
                put_frame(len, 1'b1, budget, 1'($urandom_range(0, 1)), -1);
            end else if (r < 75) begin
                put_byte(CHAR_F);
            end else if (r < 87) begin
                put_stalled_frame();
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    if ($urandom_range(0, 1) != 0) put_byte(8'($urandom_range(0, 255)));
                    else put_tick();
                end
                put_resync();
            end
        end
    endtask

    task automatic settle();
        do begin
            @(negedge aclk);
        end while (!(rx_feed_q.size() == 0 && !s_valid && want_q.size() == 0));
        repeat (8) @(negedge aclk);
    endtask

    task automatic set_timeout(input logic [15:0] v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        tmo_cfg = v;
        n_settings++;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                track_frame(s_operation, s_rx_byte);
                n_in++;
                tx_gap = pick_gap(tx_calm);
            end
            if (!s_valid || s_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_valid <= 1'b0;
                end else if (rx_feed_q.size() != 0) begin
                    next_item = rx_feed_q.pop_front();
                    s_valid <= 1'b1;
                    s_operation <= next_item.op;
                    s_rx_byte <= next_item.data;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                n_out++;
                if (m_out_kind == KIND_GOOD) n_good++;
                if (m_out_kind == KIND_CRCERR) n_crcerr++;
                if (m_out_kind == KIND_TIMEOUT) n_timeout++;
                if (want_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("tb: unexpected result kind=%0d byte=%02h len=%0d last=%0b",
                                 m_out_kind, m_out_byte, m_frame_length, m_last);
                    end
                end else begin
                    want_r = want_q.pop_front();
                    if (want_r.kind !== m_out_kind || want_r.data !== m_out_byte ||
                        want_r.flen !== m_frame_length || want_r.last !== m_last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("tb: result %0d expected kind=%0d byte=%02h len=%0d last=%0b",
                                     n_out, want_r.kind, want_r.data, want_r.flen, want_r.last);
                            $display("tb: result %0d actual   kind=%0d byte=%02h len=%0d last=%0b",
                                     n_out, m_out_kind, m_out_byte, m_frame_length, m_last);
                        end
                    end
                end
                rx_gap = pick_gap(rx_calm);
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Long receiver hold-off while the sender keeps offering transfers.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else begin
            if (s_valid && s_ready) hold_seen <= hold_seen + 1;
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
            end else if (hold_seen >= hold_at) begin
                hold_left <= HOLD_CYCLES;
                hold_at <= hold_at * 8;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: no transfer for %0d cycles", STALL_LIMIT);
            $display("framed_serial_crc32_receiver_unit: mismatch");
            $finish;
        end
    end

    initial begin
        logic [7:0]  d0;
        logic [7:0]  d1;
        logic [31:0] c;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        put_byte(CHAR_F);
        put_frame(16'd0, 1'b0, 0, 1'b0, -1);
        put_tick();
        put_frame(16'd1, 1'b0, 0, 1'b1, 255);
        put_frame(16'd2, 1'b1, 0, 1'b0, 0);
        settle();

        set_timeout(16'd0);
        put_byte(8'hFF);
        put_byte(8'hFF);
        put_tick();
        put_byte(8'h00);
        put_byte(8'h00);
        put_tick();
        run_random(40, 1'b1);
        settle();

        // With the largest timeout a frame with ticks inside it must still complete.
        set_timeout(16'hFFFF);
        d0 = 8'($urandom_range(0, 255));
        d1 = 8'($urandom_range(0, 255));
        c = crc32_shift(crc32_shift(CRC_INIT, d0), d1) ^ CRC_INIT;
        put_byte(8'h00);
        put_byte(8'h02);
        put_byte(d0);
        put_ticks(20);
        put_byte(d1);
        put_byte(c[31:24]);
        put_byte(c[23:16]);
        put_byte(c[15:8]);
        put_byte(c[7:0]);
        settle();

        foreach (mid_settings[i]) begin
            set_timeout(mid_settings[i]);
            run_random(80, 1'b1);
            settle();
        end

        set_timeout(TIMEOUT_RESET);
        run_random(30, 1'b0);
        settle();

        $display("tb: %0d input transfers and %0d result transfers under %0d timeout settings",
                 n_in, n_out, n_settings);
        $display("tb: %0d good frames, %0d CRC errors and %0d timeouts seen",
                 n_good, n_crcerr, n_timeout);
        if (mismatches == 0) begin
            $display("framed_serial_crc32_receiver_unit: match");
        end else begin
            $display("framed_serial_crc32_receiver_unit: mismatch");
        end
        $finish;
    end

endmodule
